>>> src/quaternion_vector_rotate_top_macros.svh
// assertion macros used by the quaternion vector rotate top level
`ifndef QUATERNION_VECTOR_ROTATE_TOP_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define QVR_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger sequence
`define QVR_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> src/qvr_pkg.sv
// types and constants of the quaternion vector rotate pipeline
package qvr_pkg;

  localparam int ACCEL_WIDTH    = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QUAT_WIDTH     = 16;

  // quaternion part times acceleration
  localparam int PROD1_W = QUAT_WIDTH + ACCEL_WIDTH;
  // rounded u x v, difference plus rounding bias, scaled back
  localparam int CROSS_W = PROD1_W + 2 - QUAT_FRAC_BITS;
  // quaternion part times rounded cross term
  localparam int PROD2_W = QUAT_WIDTH + CROSS_W;
  // three products, doubled, plus rounding bias
  localparam int SUM_W   = PROD2_W + 4;
  // rounded correction term
  localparam int TERM_W  = SUM_W - QUAT_FRAC_BITS;

  // stream widths, padded to whole bytes
  localparam int S_DATA_W = ((4 * QUAT_WIDTH + 3 * ACCEL_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_W = ((3 * ACCEL_WIDTH + 7) / 8) * 8;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [ACCEL_WIDTH-1:0] x;
    logic signed [ACCEL_WIDTH-1:0] y;
    logic signed [ACCEL_WIDTH-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cross_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] x;
    logic signed [TERM_W-1:0] y;
    logic signed [TERM_W-1:0] z;
  } term_t;

  // pipeline control handed to each stage module
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

>>> src/qvr_cross_a.sv
// stages one and two: products of u and v, rounded cross product u x v
module qvr_cross_a (
  input  logic              clk,
  input  logic              rst,
  input  qvr_pkg::pipe_ctl_t ctl_in,
  input  qvr_pkg::quat_t    in_quat,
  input  qvr_pkg::vec_t     in_accel,
  output logic              out_valid,
  output qvr_pkg::quat_t    out_quat,
  output qvr_pkg::vec_t     out_accel,
  output qvr_pkg::cross_t   out_cross
);
  import qvr_pkg::*;

  localparam logic signed [PROD1_W+1:0] HALF1 = (PROD1_W+2)'(1) <<< (QUAT_FRAC_BITS - 1);

  logic                       valid1;
  quat_t                      quat1;
  vec_t                       accel1;
  logic signed [PROD1_W-1:0]  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  cross_t                     cross_next;

  // difference of two products, rounded to nearest back to accel scale
  function automatic logic signed [CROSS_W-1:0] round_diff(
    input logic signed [PROD1_W-1:0] a,
    input logic signed [PROD1_W-1:0] b
  );
    logic signed [PROD1_W+1:0] biased;
    biased = (PROD1_W+2)'(a) - (PROD1_W+2)'(b) + HALF1;
    return CROSS_W'(biased >>> QUAT_FRAC_BITS);
  endfunction

  // stage one valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ctl_in.en) begin
      valid1 <= ctl_in.valid;
    end
  end

  // stage one products
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      quat1  <= in_quat;
      accel1 <= in_accel;
      p_yz   <= PROD1_W'(in_quat.y) * PROD1_W'(in_accel.z);
      p_zy   <= PROD1_W'(in_quat.z) * PROD1_W'(in_accel.y);
      p_zx   <= PROD1_W'(in_quat.z) * PROD1_W'(in_accel.x);
      p_xz   <= PROD1_W'(in_quat.x) * PROD1_W'(in_accel.z);
      p_xy   <= PROD1_W'(in_quat.x) * PROD1_W'(in_accel.y);
      p_yx   <= PROD1_W'(in_quat.y) * PROD1_W'(in_accel.x);
    end
  end

  // rounded cross product
  always_comb begin
    cross_next.x = round_diff(p_yz, p_zy);
    cross_next.y = round_diff(p_zx, p_xz);
    cross_next.z = round_diff(p_xy, p_yx);
  end

  // stage two valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl_in.en) begin
      out_valid <= valid1;
    end
  end

  // stage two data
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      out_quat  <= quat1;
      out_accel <= accel1;
      out_cross <= cross_next;
    end
  end

endmodule

>>> src/qvr_cross_c.sv
// stages three and four: u x c and w c products, rounded correction term
module qvr_cross_c (
  input  logic              clk,
  input  logic              rst,
  input  qvr_pkg::pipe_ctl_t ctl_in,
  input  qvr_pkg::quat_t    in_quat,
  input  qvr_pkg::vec_t     in_accel,
  input  qvr_pkg::cross_t   in_cross,
  output logic              out_valid,
  output qvr_pkg::vec_t     out_accel,
  output qvr_pkg::term_t    out_term
);
  import qvr_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF2 = SUM_W'(1) <<< (QUAT_FRAC_BITS - 1);

  logic                       valid3;
  vec_t                       accel3;
  logic signed [PROD2_W-1:0]  pw_x, pw_y, pw_z;
  logic signed [PROD2_W-1:0]  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  term_t                      term_next;

  // rnd(2 w c + 2 (a - b))
  function automatic logic signed [TERM_W-1:0] round_term(
    input logic signed [PROD2_W-1:0] pw,
    input logic signed [PROD2_W-1:0] a,
    input logic signed [PROD2_W-1:0] b
  );
    logic signed [SUM_W-1:0] total;
    total = SUM_W'(pw) + SUM_W'(a) - SUM_W'(b);
    total = (total <<< 1) + HALF2;
    return TERM_W'(total >>> QUAT_FRAC_BITS);
  endfunction

  // stage three valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (ctl_in.en) begin
      valid3 <= ctl_in.valid;
    end
  end

  // stage three products
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      accel3 <= in_accel;
      pw_x   <= PROD2_W'(in_quat.w) * PROD2_W'(in_cross.x);
      pw_y   <= PROD2_W'(in_quat.w) * PROD2_W'(in_cross.y);
      pw_z   <= PROD2_W'(in_quat.w) * PROD2_W'(in_cross.z);
      p_yz   <= PROD2_W'(in_quat.y) * PROD2_W'(in_cross.z);
      p_zy   <= PROD2_W'(in_quat.z) * PROD2_W'(in_cross.y);
      p_zx   <= PROD2_W'(in_quat.z) * PROD2_W'(in_cross.x);
      p_xz   <= PROD2_W'(in_quat.x) * PROD2_W'(in_cross.z);
      p_xy   <= PROD2_W'(in_quat.x) * PROD2_W'(in_cross.y);
      p_yx   <= PROD2_W'(in_quat.y) * PROD2_W'(in_cross.x);
    end
  end

  // correction terms
  always_comb begin
    term_next.x = round_term(pw_x, p_yz, p_zy);
    term_next.y = round_term(pw_y, p_zx, p_xz);
    term_next.z = round_term(pw_z, p_xy, p_yx);
  end

  // stage four valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl_in.en) begin
      out_valid <= valid3;
    end
  end

  // stage four data
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      out_accel <= accel3;
      out_term  <= term_next;
    end
  end

endmodule

>>> src/qvr_sat.sv
// stage five: add correction to the sensor vector, saturate, output register
module qvr_sat (
  input  logic              clk,
  input  logic              rst,
  input  qvr_pkg::pipe_ctl_t ctl_in,
  input  qvr_pkg::vec_t     in_accel,
  input  qvr_pkg::term_t    in_term,
  output logic              out_valid,
  output qvr_pkg::vec_t     out_world,
  output logic              out_saturated
);
  import qvr_pkg::*;

  localparam logic signed [TERM_W:0] SAT_MAX =
    (TERM_W+1)'((64'sd1 <<< (ACCEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [TERM_W:0] SAT_MIN = -SAT_MAX - (TERM_W+1)'(1);

  logic signed [TERM_W:0] sum_x, sum_y, sum_z;
  vec_t                   world_next;
  logic                   clip_next;

  function automatic logic signed [ACCEL_WIDTH-1:0] clamp(input logic signed [TERM_W:0] v);
    logic signed [ACCEL_WIDTH-1:0] r;
    priority if (v > SAT_MAX) begin
      r = ACCEL_WIDTH'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = ACCEL_WIDTH'(SAT_MIN);
    end else begin
      r = ACCEL_WIDTH'(v);
    end
    return r;
  endfunction

  function automatic logic is_clipped(input logic signed [TERM_W:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  // final add and clamp
  always_comb begin
    sum_x = (TERM_W+1)'(in_accel.x) + (TERM_W+1)'(in_term.x);
    sum_y = (TERM_W+1)'(in_accel.y) + (TERM_W+1)'(in_term.y);
    sum_z = (TERM_W+1)'(in_accel.z) + (TERM_W+1)'(in_term.z);
    world_next.x = clamp(sum_x);
    world_next.y = clamp(sum_y);
    world_next.z = clamp(sum_z);
    clip_next = is_clipped(sum_x) || is_clipped(sum_y) || is_clipped(sum_z);
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl_in.en) begin
      out_valid <= ctl_in.valid;
    end
  end

  // output data
  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      out_world     <= world_next;
      out_saturated <= clip_next;
    end
  end

endmodule

>>> src/quaternion_vector_rotate_top.sv
// top level of the quaternion vector rotate pipeline
//
//   channel   dir  fields (low bit first)
//   s_*       in   quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z
//   m_*       out  world_x, world_y, world_z; tuser: saturated
//
// five register stages: u*v products, rounded u x v, u x c and w c products,
// rounded correction, add and saturate into the output register
// one transfer per clock in and out while the output is not stalled
// rst clears only the stage valid bits, data registers are not reset
// the whole pipeline moves when the output register is empty or taken,
// so a stall freezes every stage in place and s_tready drops with it
module quaternion_vector_rotate_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z
  input  logic [qvr_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // world_x, world_y, world_z
  output logic [qvr_pkg::M_DATA_W-1:0]  m_tdata,
  // saturated
  output logic [0:0]                    m_tuser
);
  import qvr_pkg::*;

  `include "quaternion_vector_rotate_top_macros.svh"

  localparam int ACC_BASE = 4 * QUAT_WIDTH;

  logic      en;
  pipe_ctl_t ctl_a, ctl_c, ctl_s;
  quat_t     in_quat, quat2;
  vec_t      in_accel, accel2, accel4, world;
  cross_t    cross2;
  term_t     term4;
  logic      valid2, valid4, saturated;

  // pipeline advances when the output slot is free or drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // unpack input transfer
  always_comb begin
    in_quat.w  = s_tdata[0 +: QUAT_WIDTH];
    in_quat.x  = s_tdata[QUAT_WIDTH +: QUAT_WIDTH];
    in_quat.y  = s_tdata[2 * QUAT_WIDTH +: QUAT_WIDTH];
    in_quat.z  = s_tdata[3 * QUAT_WIDTH +: QUAT_WIDTH];
    in_accel.x = s_tdata[ACC_BASE +: ACCEL_WIDTH];
    in_accel.y = s_tdata[ACC_BASE + ACCEL_WIDTH +: ACCEL_WIDTH];
    in_accel.z = s_tdata[ACC_BASE + 2 * ACCEL_WIDTH +: ACCEL_WIDTH];
  end

  // stage control
  assign ctl_a = '{en: en, valid: s_tvalid};
  assign ctl_c = '{en: en, valid: valid2};
  assign ctl_s = '{en: en, valid: valid4};

  qvr_cross_a u_cross_a (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_a),
    .in_quat   (in_quat),
    .in_accel  (in_accel),
    .out_valid (valid2),
    .out_quat  (quat2),
    .out_accel (accel2),
    .out_cross (cross2)
  );

  qvr_cross_c u_cross_c (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_c),
    .in_quat   (quat2),
    .in_accel  (accel2),
    .in_cross  (cross2),
    .out_valid (valid4),
    .out_accel (accel4),
    .out_term  (term4)
  );

  qvr_sat u_sat (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (ctl_s),
    .in_accel      (accel4),
    .in_term       (term4),
    .out_valid     (m_tvalid),
    .out_world     (world),
    .out_saturated (saturated)
  );

  // pack output transfer
  assign m_tdata    = M_DATA_W'({world.z, world.y, world.x});
  assign m_tuser[0] = saturated;

  // checks
  `QVR_ASSERT_SAME(a_no_take_on_stall, m_tvalid && !m_tready, !s_tready,
    "input taken while output stalled")
  `QVR_ASSERT_SAME(a_sat_at_limit, m_tvalid && m_tuser[0],
    (world.x == {1'b0, {(ACCEL_WIDTH-1){1'b1}}}) || (world.x == {1'b1, {(ACCEL_WIDTH-1){1'b0}}}) ||
    (world.y == {1'b0, {(ACCEL_WIDTH-1){1'b1}}}) || (world.y == {1'b1, {(ACCEL_WIDTH-1){1'b0}}}) ||
    (world.z == {1'b0, {(ACCEL_WIDTH-1){1'b1}}}) || (world.z == {1'b1, {(ACCEL_WIDTH-1){1'b0}}}),
    "saturated flag without a clipped component")
  `QVR_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 s_tready ##1 s_tready ##1 s_tready ##1 s_tready,
    m_tvalid, "accepted item did not reach the output after four moves")

endmodule

>>> tb/quaternion_vector_rotate_top_test.sv
// self-checking testbench for the quaternion vector rotate top level
`timescale 1ns / 100ps

module quaternion_vector_rotate_top_test;
  import qvr_pkg::*;

  localparam int QW = QUAT_WIDTH;
  localparam int AW = ACCEL_WIDTH;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  // one rotated vector with its clip flag
  typedef struct {
    vec_t world;
    logic clip;
  } rotation_t;

  // expected world vectors in transfer order, checked against the output stream
  class rotation_scoreboard;
    rotation_t expected_q[$];
    int mismatches;
    int checked;
    int clipped;

    // fixed-point round to nearest, ties toward plus infinity
    function automatic longint round_frac(longint val);
      return (val + (longint'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    endfunction

    // clamp to the signed acceleration range
    function automatic longint clamp_accel(longint val, ref logic clip);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (AW - 1)) - 1;
      lo = -hi - 1;
      if (val > hi) begin
        clip = 1'b1;
        return hi;
      end
      if (val < lo) begin
        clip = 1'b1;
        return lo;
      end
      return val;
    endfunction

    // v' = v + 2w (u x v) + 2 u x (u x v), rounded at each rescale
    function automatic rotation_t rotate_vector(quat_t q, vec_t v);
      longint qw, qx, qy, qz, ax, ay, az;
      longint cx, cy, cz, dx, dy, dz, tx, ty, tz;
      rotation_t res;
      qw = $signed(q.w);
      qx = $signed(q.x);
      qy = $signed(q.y);
      qz = $signed(q.z);
      ax = $signed(v.x);
      ay = $signed(v.y);
      az = $signed(v.z);
      cx = round_frac(qy * az - qz * ay);
      cy = round_frac(qz * ax - qx * az);
      cz = round_frac(qx * ay - qy * ax);
      dx = qy * cz - qz * cy;
      dy = qz * cx - qx * cz;
      dz = qx * cy - qy * cx;
      tx = round_frac(2 * qw * cx + 2 * dx);
      ty = round_frac(2 * qw * cy + 2 * dy);
      tz = round_frac(2 * qw * cz + 2 * dz);
      res.clip = 1'b0;
      res.world.x = AW'(clamp_accel(ax + tx, res.clip));
      res.world.y = AW'(clamp_accel(ay + ty, res.clip));
      res.world.z = AW'(clamp_accel(az + tz, res.clip));
      return res;
    endfunction

    function void note_input(quat_t q, vec_t v);
      expected_q.push_back(rotate_vector(q, v));
    endfunction

    function void check_result(vec_t world, logic clip);
      rotation_t exp_rot;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b", $realtime,
                   $signed(world.x), $signed(world.y), $signed(world.z), clip);
        return;
      end
      exp_rot = expected_q.pop_front();
      checked++;
      if (exp_rot.clip)
        clipped++;
      if (world.x !== exp_rot.world.x || world.y !== exp_rot.world.y ||
          world.z !== exp_rot.world.z || clip !== exp_rot.clip) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                   $realtime, $signed(exp_rot.world.x), $signed(exp_rot.world.y),
                   $signed(exp_rot.world.z), exp_rot.clip, $signed(world.x),
                   $signed(world.y), $signed(world.z), clip);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int vectors_sent = 0;
  rotation_scoreboard board = new;

  quaternion_vector_rotate_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // input and output transfer monitors
  always @(posedge clk) begin
    quat_t q;
    vec_t v;
    vec_t world;
    if (!rst && s_tvalid && s_tready) begin
      q.w = s_tdata[0 +: QW];
      q.x = s_tdata[QW +: QW];
      q.y = s_tdata[2*QW +: QW];
      q.z = s_tdata[3*QW +: QW];
      v.x = s_tdata[4*QW +: AW];
      v.y = s_tdata[4*QW + AW +: AW];
      v.z = s_tdata[4*QW + 2*AW +: AW];
      board.note_input(q, v);
    end
    if (!rst && m_tvalid && m_tready) begin
      world.x = m_tdata[0 +: AW];
      world.y = m_tdata[AW +: AW];
      world.z = m_tdata[2*AW +: AW];
      board.check_result(world, m_tuser[0]);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("FAIL");
      $finish;
    end
  end

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = QW'(w);
    q.x = QW'(x);
    q.y = QW'(y);
    q.z = QW'(z);
    return q;
  endfunction

  function automatic vec_t make_vec(int x, int y, int z);
    vec_t v;
    v.x = AW'(x);
    v.y = AW'(y);
    v.z = AW'(z);
    return v;
  endfunction

  // sender: random gap, then hold the transfer until accepted; starts and ends at negedge
  task automatic send_item(input quat_t q, input vec_t v);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {v.z, v.y, v.x, q.z, q.y, q.x, q.w};
    do @(posedge clk); while (!s_tready);
    vectors_sent++;
    @(negedge clk);
  endtask

  // identity, zero, half turns, quarter turns, non-unit, overflow, rounding ties
  task automatic send_directed();
    send_item(make_quat(16384, 0, 0, 0), make_vec(0, 0, 0));
    send_item(make_quat(16384, 0, 0, 0), make_vec(32767, -32768, 1));
    send_item(make_quat(0, 0, 0, 0), make_vec(-32768, 32767, -1));
    send_item(make_quat(11585, 0, 0, 11585), make_vec(2048, 0, 0));
    send_item(make_quat(0, 16384, 0, 0), make_vec(0, 2048, -2048));
    send_item(make_quat(0, 0, -16384, 0), make_vec(1000, -2000, 3000));
    send_item(make_quat(16384, 16384, 16384, 16384), make_vec(2048, 2048, 2048));
    send_item(make_quat(-32768, -32768, -32768, -32768), make_vec(32767, 32767, 32767));
    send_item(make_quat(-32768, -32768, -32768, -32768), make_vec(-32768, -32768, -32768));
    send_item(make_quat(32767, 32767, 32767, 32767), make_vec(-32768, 32767, -32768));
    send_item(make_quat(-16384, 0, 0, 0), make_vec(12345, -12345, 0));
    send_item(make_quat(0, 16384, 0, 0), make_vec(-32768, -32768, -32768));
    send_item(make_quat(-32768, 0, 0, 0), make_vec(-32768, 32767, 5));
    send_item(make_quat(0, 8192, 0, 0), make_vec(0, 1, -1));
    send_item(make_quat(0, 8192, 0, 0), make_vec(0, -1, 1));
    send_item(make_quat(11585, 0, 11585, 0), make_vec(32767, 0, 0));
    send_item(make_quat(11585, -11585, 0, 0), make_vec(0, -32768, 32767));
    send_item(make_quat(0, 0, 0, 16384), make_vec(-32768, -32768, 0));
    send_item(make_quat(21845, -21846, 21845, -21846), make_vec(21845, -21846, 21845));
    send_item(make_quat(-1, -1, -1, -1), make_vec(-1, -1, -1));
  endtask

  // unit or moderate quaternions and mostly moderate vectors, with full-range noise mixed in
  task automatic send_random();
    real a, b, c, d, norm;
    int kind;
    quat_t q;
    vec_t v;
    kind = $urandom_range(99);
    if (kind < 45) begin
      a = real'(int'($urandom_range(65535)) - 32768);
      b = real'(int'($urandom_range(65535)) - 32768);
      c = real'(int'($urandom_range(65535)) - 32768);
      d = real'(int'($urandom_range(65535)) - 32768);
      norm = $sqrt(a * a + b * b + c * c + d * d);
      if (norm == 0.0)
        norm = 1.0;
      q = make_quat($rtoi(a / norm * 16384.0), $rtoi(b / norm * 16384.0),
                    $rtoi(c / norm * 16384.0), $rtoi(d / norm * 16384.0));
    end else if (kind < 75) begin
      q = make_quat(int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384,
                    int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384);
    end else begin
      q = make_quat($urandom, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(99) < 60)
      v = make_vec(int'($urandom_range(16384)) - 8192, int'($urandom_range(16384)) - 8192,
                   int'($urandom_range(16384)) - 8192);
    else
      v = make_vec($urandom, $urandom, $urandom);
    send_item(q, v);
  endtask

  // hold off the sender until the pipeline has returned every result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed();
    wait_drained();

    // traffic phases: free flow, sparse input, heavy back-pressure, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 76;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 76;
        end
        default: begin
          idle_pct = 36;
          stall_pct = 36;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_random();
      wait_drained();
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d vectors over four traffic mixes, %0d results checked, %0d clipped",
             vectors_sent, board.checked, board.clipped);
    $display("mismatches %0d, results outstanding %0d", board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
